// ===== design/bct_pkg.sv =====
// Shared types and constants for the blob centroid tracker.
// Used by bct_avg_div and blob_centroid_tracker_core; no dependencies.
`timescale 1ns / 1ps
package bct_pkg;

  localparam int unsigned BLOB_SLOTS = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned AVG_W      = 17;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned GAP_W      = 4;

  localparam logic [6:0] SCALE      = 7'd100;
  localparam logic [5:0] HALF_SCALE = 6'd50;

  localparam logic [LEN_W-1:0]   RUN_MAX    = 11'd2047;
  localparam logic [COORD_W-1:0] HEIGHT_MAX = 10'd1023;
  localparam logic [GAP_W-1:0]   GAP_MAX    = 4'd15;

  // configuration register indexes
  localparam logic CFG_LAST_COLUMN = 1'b0;
  localparam logic CFG_MAX_GAP     = 1'b1;

  typedef struct packed {
    logic [AVG_W-1:0]   x_avg;
    logic [AVG_W-1:0]   y_avg;
    logic [COORD_W-1:0] height;
    logic [LEN_W-1:0]   last_width;
    logic [COORD_W-1:0] last_row;
  } blob_entry_t;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_RUN_DIV  = 15'b000000000000010,
    S_SCAN_RD  = 15'b000000000000100,
    S_SCAN_CHK = 15'b000000000001000,
    S_MRG_X    = 15'b000000000010000,
    S_MRG_Y    = 15'b000000000100000,
    S_SHIFT_RD = 15'b000000001000000,
    S_SHIFT_WR = 15'b000000010000000,
    S_PLACE    = 15'b000000100000000,
    S_UPD_GO   = 15'b000001000000000,
    S_UPD_X    = 15'b000010000000000,
    S_UPD_Y    = 15'b000100000000000,
    S_EMIT_RD  = 15'b001000000000000,
    S_EMIT_LD  = 15'b010000000000000,
    S_OUT      = 15'b100000000000000
  } state_e;

endpackage

// ===== design/blob_centroid_tracker_core.sv =====
// Blob centroid tracker top level: pixel stream in, blob centroids out.
// Depends on bct_pkg and bct_avg_div.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries pixel items in row-major order (tuser 0) or an end of
//   frame (tuser 1). m_axis returns one item per live blob at end of frame,
//   tlast on the final one; an empty frame gives one item with blob_valid 0.
//   cfg_we_i writes last_column (index 0) or max_gap (index 1); the user
//   must write only while idle; the block itself does not enforce it.
// Processing: one item at a time. An off pixel that does not close a run
//   only updates the run state. An on pixel goes through the serial divider
//   (17 quotient bits). A run closure walks the blob table held in one
//   synchronous RAM slot by slot; a merge runs two divisions and slides each
//   later slot down; the update runs two more. Frame end emits blobs in turn.
// Reset clears the blob count, run state and flags; table contents are only
//   read below the blob count and need no clearing. Registers return to
//   639 and 4. While m_axis_tready is low the result item holds and no
//   input item is taken.
module blob_centroid_tracker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_on[0], col[10:1], row[20:11], zero pad
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // blob_index[3:0], centroid_x[20:4],
                                      // centroid_y[37:21], zero pad
  output logic [1:0]  m_axis_tuser,   // blob_valid[0], table_full[1]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [9:0]  cfg_data_i
);
  import bct_pkg::*;

  state_e             state_q, state_d;
  logic [COORD_W-1:0] last_col_q, last_col_d;
  logic [GAP_W-1:0]   max_gap_q, max_gap_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [LEN_W-1:0]   run_len_q, run_len_d;
  logic [AVG_W-1:0]   run_x_q, run_x_d;
  logic [GAP_W-1:0]   gap_q, gap_d;
  logic               active_q, active_d;
  logic               full_q, full_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   mv_q, mv_d;
  logic               found_q, found_d;
  logic [SLOT_W-1:0]  fidx_q, fidx_d;
  blob_entry_t        fent_q, fent_d;
  logic [AVG_W-1:0]   oth_y_q, oth_y_d;
  logic [COORD_W-1:0] row_q, row_d;
  logic               rend_q, rend_d;
  logic               ovalid_q, ovalid_d;
  logic [39:0]        odata_q, odata_d;
  logic [1:0]         ouser_q, ouser_d;
  logic               olast_q, olast_d;

  logic               go_q, go_d;
  logic [AVG_W-1:0]   da_q, da_d, dv_q, dv_d;
  logic [LEN_W-1:0]   dn_q, dn_d;
  logic               div_done;
  logic [AVG_W-1:0]   div_res;

  blob_entry_t        mem [BLOB_SLOTS];
  blob_entry_t        rdata_q, wdata;
  logic               we;
  logic [SLOT_W-1:0]  waddr, raddr;

  logic               in_acc, px_on, row_end, hit;
  logic [COORD_W-1:0] px_col, px_row;
  logic [GAP_W-1:0]   gap_inc;
  logic [10:0]        row_diff;
  logic [19:0]        hi_sum, lo_sum;
  logic [CNT_W-1:0]   idx_n, mv_n, cnt_m;

  bct_avg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go_q),
    .avg_i  (da_q),
    .val_i  (dv_q),
    .n_i    (dn_q),
    .done_o (div_done),
    .res_o  (div_res)
  );

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign px_on   = s_axis_tdata[0];
  assign px_col  = s_axis_tdata[10:1];
  assign px_row  = s_axis_tdata[20:11];
  assign row_end = px_col >= last_col_q;
  assign gap_inc = (gap_q < GAP_MAX) ? gap_q + 1'b1 : gap_q;

  // span overlap with tolerance, both sides rearranged to avoid subtraction
  assign row_diff = {1'b0, row_q} - {1'b0, rdata_q.last_row};
  assign hi_sum   = 20'(run_x_q) + 20'(run_len_q) * 20'(HALF_SCALE)
                  + 20'(rdata_q.last_width) * 20'(HALF_SCALE)
                  + 20'(max_gap_q) * 20'(SCALE);
  assign lo_sum   = 20'(rdata_q.x_avg) + 20'(run_len_q) * 20'(HALF_SCALE)
                  + 20'(rdata_q.last_width) * 20'(HALF_SCALE)
                  + 20'(max_gap_q) * 20'(SCALE);
  assign hit = ($signed(row_diff) <= $signed({7'b0, max_gap_q}))
             && (hi_sum >= 20'(rdata_q.x_avg)) && (20'(run_x_q) <= lo_sum);

  assign idx_n = idx_q + 1'b1;
  assign mv_n  = mv_q + 1'b1;
  assign cnt_m = count_q - 1'b1;

  always_comb begin
    state_d    = state_q;
    last_col_d = last_col_q;
    max_gap_d  = max_gap_q;
    count_d    = count_q;
    run_len_d  = run_len_q;
    run_x_d    = run_x_q;
    gap_d      = gap_q;
    active_d   = active_q;
    full_d     = full_q;
    idx_d      = idx_q;
    mv_d       = mv_q;
    found_d    = found_q;
    fidx_d     = fidx_q;
    fent_d     = fent_q;
    oth_y_d    = oth_y_q;
    row_d      = row_q;
    rend_d     = rend_q;
    ovalid_d   = ovalid_q;
    odata_d    = odata_q;
    ouser_d    = ouser_q;
    olast_d    = olast_q;
    go_d       = 1'b0;
    da_d       = da_q;
    dv_d       = dv_q;
    dn_d       = dn_q;
    we         = 1'b0;
    waddr      = mv_q[SLOT_W-1:0];
    wdata      = rdata_q;
    raddr      = idx_q[SLOT_W-1:0];

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LAST_COLUMN: last_col_d = cfg_data_i;
        CFG_MAX_GAP:     max_gap_d  = cfg_data_i[GAP_W-1:0];
        default:         ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          row_d  = px_row;
          rend_d = row_end;
          if (s_axis_tuser) begin
            if (count_q == '0) begin
              odata_d  = '0;
              ouser_d  = {full_q, 1'b0};
              olast_d  = 1'b1;
              ovalid_d = 1'b1;
              state_d  = S_OUT;
            end else begin
              idx_d   = '0;
              state_d = S_EMIT_RD;
            end
          end else if (!full_q) begin
            if (px_on) begin
              go_d    = 1'b1;
              da_d    = run_x_q;
              dv_d    = AVG_W'(px_col) * AVG_W'(SCALE);
              dn_d    = run_len_q;
              state_d = S_RUN_DIV;
            end else if (active_q) begin
              gap_d = gap_inc;
              if (gap_inc >= max_gap_q || row_end) begin
                idx_d   = '0;
                found_d = 1'b0;
                state_d = (count_q == '0) ? S_PLACE : S_SCAN_RD;
              end
            end
          end
        end
      end
      S_RUN_DIV: begin
        if (div_done) begin
          run_x_d   = div_res;
          run_len_d = (run_len_q < RUN_MAX) ? run_len_q + 1'b1 : run_len_q;
          gap_d     = '0;
          active_d  = 1'b1;
          if (rend_q) begin
            idx_d   = '0;
            found_d = 1'b0;
            state_d = (count_q == '0) ? S_PLACE : S_SCAN_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SCAN_RD: state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (hit && found_q) begin
          // fold this blob into the first match, then compact it away
          go_d    = 1'b1;
          da_d    = fent_q.x_avg;
          dv_d    = rdata_q.x_avg;
          dn_d    = LEN_W'(2);
          oth_y_d = rdata_q.y_avg;
          state_d = S_MRG_X;
        end else begin
          if (hit) begin
            found_d = 1'b1;
            fidx_d  = idx_q[SLOT_W-1:0];
            fent_d  = rdata_q;
          end
          idx_d   = idx_n;
          state_d = (idx_n == count_q) ? S_PLACE : S_SCAN_RD;
        end
      end
      S_MRG_X: begin
        if (div_done) begin
          fent_d.x_avg = div_res;
          go_d         = 1'b1;
          da_d         = fent_q.y_avg;
          dv_d         = oth_y_q;
          dn_d         = LEN_W'(2);
          state_d      = S_MRG_Y;
        end
      end
      S_MRG_Y: begin
        if (div_done) begin
          fent_d.y_avg = div_res;
          count_d      = cnt_m;
          mv_d         = idx_q;
          state_d      = (idx_q < cnt_m) ? S_SHIFT_RD : S_PLACE;
        end
      end
      S_SHIFT_RD: begin
        raddr   = mv_n[SLOT_W-1:0];
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        we      = 1'b1;
        waddr   = mv_q[SLOT_W-1:0];
        wdata   = rdata_q;
        mv_d    = mv_n;
        // re-examine the slot that slid into the current position
        state_d = (mv_n < count_q) ? S_SHIFT_RD : S_SCAN_RD;
      end
      S_PLACE: begin
        if (found_q) begin
          state_d = S_UPD_GO;
        end else if (count_q == CNT_W'(BLOB_SLOTS)) begin
          full_d    = 1'b1;
          run_len_d = '0;
          run_x_d   = '0;
          gap_d     = '0;
          active_d  = 1'b0;
          state_d   = S_IDLE;
        end else begin
          fidx_d  = count_q[SLOT_W-1:0];
          fent_d  = '0;
          count_d = count_q + 1'b1;
          state_d = S_UPD_GO;
        end
      end
      S_UPD_GO: begin
        go_d    = 1'b1;
        da_d    = fent_q.x_avg;
        dv_d    = run_x_q;
        dn_d    = fent_q.last_width;
        state_d = S_UPD_X;
      end
      S_UPD_X: begin
        if (div_done) begin
          fent_d.x_avg = div_res;
          go_d         = 1'b1;
          da_d         = fent_q.y_avg;
          dv_d         = AVG_W'(row_q) * AVG_W'(SCALE);
          dn_d         = LEN_W'(fent_q.height);
          state_d      = S_UPD_Y;
        end
      end
      S_UPD_Y: begin
        if (div_done) begin
          we               = 1'b1;
          waddr            = fidx_q;
          wdata.x_avg      = fent_q.x_avg;
          wdata.y_avg      = div_res;
          wdata.height     = (fent_q.height < HEIGHT_MAX) ? fent_q.height + 1'b1
                                                           : fent_q.height;
          wdata.last_width = run_len_q;
          wdata.last_row   = row_q;
          run_len_d        = '0;
          run_x_d          = '0;
          gap_d            = '0;
          active_d         = 1'b0;
          state_d          = S_IDLE;
        end
      end
      S_EMIT_RD: state_d = S_EMIT_LD;
      S_EMIT_LD: begin
        odata_d  = {2'b0, rdata_q.y_avg + AVG_W'(HALF_SCALE),
                    rdata_q.x_avg + AVG_W'(HALF_SCALE), idx_q[SLOT_W-1:0]};
        ouser_d  = {full_q, 1'b1};
        olast_d  = idx_n == count_q;
        ovalid_d = 1'b1;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) begin
          ovalid_d = 1'b0;
          if (olast_q) begin
            count_d   = '0;
            full_d    = 1'b0;
            run_len_d = '0;
            run_x_d   = '0;
            gap_d     = '0;
            active_d  = 1'b0;
            state_d   = S_IDLE;
          end else begin
            idx_d   = idx_n;
            state_d = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      last_col_q <= 10'd639;
      max_gap_q  <= 4'd4;
      count_q    <= '0;
      run_len_q  <= '0;
      run_x_q    <= '0;
      gap_q      <= '0;
      active_q   <= 1'b0;
      full_q     <= 1'b0;
      ovalid_q   <= 1'b0;
      go_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      last_col_q <= last_col_d;
      max_gap_q  <= max_gap_d;
      count_q    <= count_d;
      run_len_q  <= run_len_d;
      run_x_q    <= run_x_d;
      gap_q      <= gap_d;
      active_q   <= active_d;
      full_q     <= full_d;
      ovalid_q   <= ovalid_d;
      go_q       <= go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    mv_q    <= mv_d;
    found_q <= found_d;
    fidx_q  <= fidx_d;
    fent_q  <= fent_d;
    oth_y_q <= oth_y_d;
    row_q   <= row_d;
    rend_q  <= rend_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
    olast_q <= olast_d;
    da_q    <= da_d;
    dv_q    <= dv_d;
    dn_q    <= dn_d;
  end

  // blob table RAM, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(BLOB_SLOTS))
    else $error("blob count beyond table size");

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while result pending");

  a_full_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tuser && full_q) |=> $stable(run_len_q) && state_q == S_IDLE)
    else $error("pixel processed after table full");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> count_q == '0 && !full_q)
    else $error("frame state not cleared after last result");
`endif

endmodule

// ===== design/bct_avg_div.sv =====
// Moving average step: avg + (v - avg) / (n + 1), truncating toward zero.
// Restoring divider, one quotient bit per cycle. Depends on bct_pkg.
`timescale 1ns / 1ps
module bct_avg_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  logic [bct_pkg::AVG_W-1:0] avg_i,
  input  logic [bct_pkg::AVG_W-1:0] val_i,
  input  logic [bct_pkg::LEN_W-1:0] n_i,
  output logic                      done_o,
  output logic [bct_pkg::AVG_W-1:0] res_o
);
  import bct_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [AVG_W-1:0]   a_q, a_d;
  logic [AVG_W-1:0]   mag_q, mag_d;
  logic [AVG_W-1:0]   quo_q, quo_d;
  logic [LEN_W:0]     div_q, div_d;
  logic [LEN_W:0]     rem_q, rem_d;
  logic               neg_q, neg_d;
  logic [LEN_W+1:0]   rem_sh;

  assign rem_sh = {rem_q, mag_q[AVG_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    mag_d  = mag_q;
    quo_d  = quo_q;
    div_d  = div_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    if (go_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(AVG_W);
      a_d    = avg_i;
      neg_d  = val_i < avg_i;
      mag_d  = (val_i < avg_i) ? (avg_i - val_i) : (val_i - avg_i);
      div_d  = {1'b0, n_i} + 1'b1;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      mag_d = {mag_q[AVG_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d = (LEN_W+1)'(rem_sh - {1'b0, div_q});
        quo_d = {quo_q[AVG_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[LEN_W:0];
        quo_d = {quo_q[AVG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    mag_q <= mag_d;
    quo_q <= quo_d;
    div_q <= div_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign res_o  = neg_q ? (a_q - quo_q) : (a_q + quo_q);

endmodule

// ===== verif/bct_scoreboard.sv =====
// Blob centroid tracker checker: watches the pixel, result and register channels,
// predicts the blob reports of each frame and compares them with the results.
// Depends on bct_pkg.
`timescale 1ns / 1ps
module bct_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  output int          mismatch_count_o,
  output int          reports_due_o
);
  import bct_pkg::*;

  typedef struct packed {
    logic             blob_valid;
    logic [3:0]       blob_index;
    logic [AVG_W-1:0] centroid_x;
    logic [AVG_W-1:0] centroid_y;
    logic             table_full;
    logic             last;
  } blob_report_t;

  blob_report_t frame_reports[$];

  logic [COORD_W-1:0] last_column;
  logic [GAP_W-1:0]   max_gap;

  logic [AVG_W-1:0]   bx[BLOB_SLOTS];
  logic [AVG_W-1:0]   by[BLOB_SLOTS];
  logic [COORD_W-1:0] bh[BLOB_SLOTS];
  logic [LEN_W-1:0]   bw[BLOB_SLOTS];
  logic [COORD_W-1:0] br[BLOB_SLOTS];
  int unsigned        live_blobs;
  logic [LEN_W-1:0]   run_len;
  logic [AVG_W-1:0]   run_x;
  logic [GAP_W-1:0]   gap_cnt;
  logic               gap_on;
  logic               halted;

  function automatic logic [AVG_W-1:0] cum_avg(longint avg, longint v, longint n);
    longint a;
    a = avg + (v - avg) / (n + 1);
    return a[AVG_W-1:0];
  endfunction

  task automatic wipe_slot(int s);
    bx[s] = '0; by[s] = '0; bh[s] = '0; bw[s] = '0; br[s] = '0;
  endtask

  task automatic wipe_run();
    run_len = '0; run_x = '0; gap_cnt = '0; gap_on = 1'b0;
  endtask

  task automatic wipe_frame();
    for (int s = 0; s < BLOB_SLOTS; s++) wipe_slot(s);
    live_blobs = 0;
    halted = 1'b0;
    wipe_run();
  endtask

  task automatic close_run(logic [COORD_W-1:0] row);
    longint tol, x, hw, obx, obw;
    int found, i, t;
    logic hit;
    tol = longint'(max_gap) * 100;
    x   = longint'(run_x);
    hw  = longint'(run_len) * 50;
    found = -1;
    i = 0;
    while (i < live_blobs) begin
      hit = 1'b0;
      if (longint'(row) - longint'(br[i]) <= longint'(max_gap)) begin
        obx = longint'(bx[i]);
        obw = longint'(bw[i]) * 50;
        hit = (x + hw + tol >= obx - obw) && (x - hw <= obx + obw + tol);
      end
      if (!hit) begin
        i++;
      end else if (found < 0) begin
        found = i;
        i++;
      end else begin
        // fold the later blob into the first match, slide the rest down
        bx[found] = cum_avg(bx[found], bx[i], 2);
        by[found] = cum_avg(by[found], by[i], 2);
        live_blobs--;
        for (t = i; t < live_blobs; t++) begin
          bx[t] = bx[t+1]; by[t] = by[t+1]; bh[t] = bh[t+1];
          bw[t] = bw[t+1]; br[t] = br[t+1];
        end
        wipe_slot(live_blobs);
      end
    end
    if (found < 0) begin
      if (live_blobs >= BLOB_SLOTS) begin
        halted = 1'b1;
        wipe_run();
        return;
      end
      found = live_blobs;
      wipe_slot(live_blobs);
      live_blobs++;
    end
    bx[found] = cum_avg(bx[found], run_x, bw[found]);
    by[found] = cum_avg(by[found], longint'(row) * 100, bh[found]);
    bw[found] = run_len;
    br[found] = row;
    if (bh[found] < HEIGHT_MAX) bh[found]++;
    wipe_run();
  endtask

  task automatic predict_pixel(logic on, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    logic row_end;
    row_end = col >= last_column;
    if (halted) return;
    if (on) begin
      run_x = cum_avg(run_x, longint'(col) * 100, run_len);
      if (run_len < RUN_MAX) run_len++;
      gap_cnt = '0;
      gap_on = 1'b1;
      if (row_end) close_run(row);
    end else if (gap_on) begin
      if (gap_cnt < GAP_MAX) gap_cnt++;
      if (gap_cnt >= max_gap || row_end) close_run(row);
    end
  endtask

  task automatic predict_frame_end();
    blob_report_t r;
    if (live_blobs == 0) begin
      r = '0;
      r.table_full = halted;
      r.last = 1'b1;
      frame_reports.push_back(r);
    end else begin
      for (int k = 0; k < live_blobs; k++) begin
        r.blob_valid = 1'b1;
        r.blob_index = k[3:0];
        r.centroid_x = bx[k] + AVG_W'(HALF_SCALE);
        r.centroid_y = by[k] + AVG_W'(HALF_SCALE);
        r.table_full = halted;
        r.last = (k + 1 == live_blobs);
        frame_reports.push_back(r);
      end
    end
    wipe_frame();
  endtask

  task automatic check_report();
    blob_report_t got, exp_r;
    got.blob_index = m_axis_tdata[3:0];
    got.centroid_x = m_axis_tdata[20:4];
    got.centroid_y = m_axis_tdata[37:21];
    got.blob_valid = m_axis_tuser[0];
    got.table_full = m_axis_tuser[1];
    got.last       = m_axis_tlast;
    if (frame_reports.size() == 0) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10)
        $display("unexpected result item: %p", got);
      return;
    end
    exp_r = frame_reports.pop_front();
    if (got !== exp_r) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10)
        $display("result mismatch: expected %p, got %p", exp_r, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_column = 10'd639;
      max_gap = 4'd4;
      wipe_frame();
      frame_reports.delete();
      mismatch_count_o = 0;
      reports_due_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_LAST_COLUMN) last_column = cfg_data_i;
        else max_gap = cfg_data_i[GAP_W-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) check_report();
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) predict_frame_end();
        else predict_pixel(s_axis_tdata[0], s_axis_tdata[10:1], s_axis_tdata[20:11]);
      end
      reports_due_o = frame_reports.size();
    end
  end

endmodule

// ===== verif/blob_centroid_tracker_core_test.sv =====
// Testbench top for the blob centroid tracker: drives pixel frames and register
// writes, stalls the result side, and gives the verdict. Depends on bct_pkg,
// bct_scoreboard and blob_centroid_tracker_core.
`timescale 1ns / 1ps
module blob_centroid_tracker_core_test;
  import bct_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 1500;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [9:0]  cfg_data_i;

  int  mismatches;
  int  reports_due;
  int  cycles;
  int  pixels_sent;
  bit  quiet;
  bit  hold_go;
  bit  hold_done;
  int  rx_stall;
  int  hold_left;

  blob_centroid_tracker_core u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  bct_scoreboard u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mismatch_count_o(mismatches),
    .reports_due_o(reports_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      if (hold_left == 0) hold_left = 600;
      hold_left--;
      if (hold_left == 0) hold_done = 1'b1;
      m_axis_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(5) == 0) begin
      rx_stall = $urandom_range(12, 1) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(logic cmd, logic on, logic [9:0] col, logic [9:0] row);
    if (!quiet && $urandom_range(4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, row, col, on};
    do @(posedge clk_i); while (!s_axis_tready);
    if (!cmd) pixels_sent++;
  endtask

  task automatic pixel(logic on, logic [9:0] col, logic [9:0] row);
    send_item(1'b0, on, col, row);
  endtask

  task automatic frame_end();
    send_item(1'b1, 1'($urandom), 10'($urandom), 10'($urandom));
  endtask

  // wait until the block is idle, then write both registers
  task automatic set_regs(logic [9:0] last_col, logic [9:0] gap);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (reports_due == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LAST_COLUMN;
    cfg_data_i <= last_col;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_GAP;
    cfg_data_i <= gap;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // raster frame with a few random rectangles and some speckle
  task automatic random_frame(int last_col, int rows);
    int nrect;
    int c0[3], c1[3], r0[3], r1[3];
    logic on;
    nrect = $urandom_range(3, 1);
    for (int k = 0; k < nrect; k++) begin
      c0[k] = $urandom_range(last_col);
      c1[k] = c0[k] + $urandom_range(4);
      r0[k] = $urandom_range(rows - 1);
      r1[k] = r0[k] + $urandom_range(2);
    end
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c <= last_col; c++) begin
        on = 1'b0;
        for (int k = 0; k < nrect; k++)
          if (c >= c0[k] && c <= c1[k] && r >= r0[k] && r <= r1[k]) on = 1'b1;
        if ($urandom_range(29) == 0) on = ~on;
        if ($urandom_range(39) == 0) pixel(1'($urandom), 10'($urandom), 10'($urandom));
        else pixel(on, 10'(c), 10'(r));
      end
    end
  endtask

  initial begin
    int frames;
    cycles = 0;
    pixels_sent = 0;
    quiet = 1'b0;
    hold_go = 1'b0;
    hold_done = 1'b0;
    rx_stall = 0;
    hold_left = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_LAST_COLUMN;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: empty frame, ignored off pixel, on pixel at row end, open run dropped
    frame_end();
    pixel(1'b0, 10'd5, 10'd0);
    pixel(1'b1, 10'd639, 10'd0);
    pixel(1'b1, 10'd1023, 10'd1023);
    pixel(1'b1, 10'd0, 10'd0);
    pixel(1'b0, 10'd700, 10'd1);
    pixel(1'b1, 10'd10, 10'd2);
    frame_end();

    // widest row, widest gap: saturate the gap counter
    set_regs(10'd1023, 10'd15);
    pixel(1'b1, 10'd0, 10'd0);
    for (int k = 1; k <= 16; k++) pixel(1'b0, 10'(k), 10'd0);
    pixel(1'b1, 10'd512, 10'd1);
    pixel(1'b1, 10'd513, 10'd1);
    pixel(1'b0, 10'd1023, 10'd1);
    frame_end();

    // isolated dots overflow the table
    set_regs(10'd31, 10'd1);
    for (int r = 0; r < 6; r += 2)
      for (int c = 0; c < 32; c += 4) begin
        pixel(1'b1, 10'(c), 10'(r));
        pixel(1'b0, 10'(c + 1), 10'(r));
      end
    pixel(1'b1, 10'd2, 10'd8);
    frame_end();

    // zero gap: first off pixel closes a run, no tolerance; two-pixel rows
    set_regs(10'd1, 10'd0);
    for (int r = 0; r < 3; r++) begin
      pixel(1'b1, 10'd0, 10'(r));
      pixel(1'b0, 10'd1, 10'(r));
    end
    frame_end();

    frames = 0;
    while (pixels_sent < 185 && frames < 20) begin
      if (frames % 3 == 0) begin
        case ($urandom_range(3))
          0: set_regs(10'd3, 10'($urandom_range(15, 1)));
          1: set_regs(10'd7, 10'($urandom_range(3, 1)));
          2: set_regs(10'd15, 10'($urandom_range(15, 1)));
          default: set_regs(10'd11, 10'($urandom_range(6, 1)));
        endcase
      end
      if (pixels_sent >= 150) quiet = 1'b1;
      random_frame(3 + 4 * $urandom_range(1), $urandom_range(4, 2));
      // hold off the results while the next frame keeps offering pixels
      if (frames == 1) hold_go = 1'b1;
      frame_end();
      frames++;
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    wait (reports_due == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && reports_due == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bct_pkg.sv
design/bct_avg_div.sv
design/blob_centroid_tracker_core.sv
verif/bct_scoreboard.sv
verif/blob_centroid_tracker_core_test.sv
